[sv/ccz_pkg.sv]
// Shared types and constants of the calendar clock with zone shift.
`default_nettype none

package ccz_pkg;

  // Item kinds carried in the input tuser
  typedef enum logic [1:0] {
    ModeTick = 2'd0,
    ModeSet  = 2'd1,
    ModeZone = 2'd2
  } ccz_mode_e;

  localparam logic [5:0]  SecMax     = 6'd59;
  localparam logic [5:0]  MinMax     = 6'd59;
  localparam logic [4:0]  HourMax    = 5'd23;
  localparam logic [5:0]  HoursDay   = 6'd24;
  localparam logic [3:0]  MonthMax   = 4'd12;
  localparam logic [13:0] YearMax    = 14'd9999;
  localparam logic [4:0]  OffsetMax  = 5'd23;
  localparam logic [2:0]  WdUnknown  = 3'd0;
  localparam logic [2:0]  WdMonday   = 3'd1;
  localparam logic [2:0]  WdSunday   = 3'd7;

  // Reset values of the clock state
  localparam logic [4:0]  OffsetReset = 5'd6;
  localparam logic [4:0]  DayReset    = 5'd1;
  localparam logic [3:0]  MonthReset  = 4'd1;
  localparam logic [13:0] YearReset   = 14'd2000;

  // Complete clock state, also the result of every transaction
  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic        zone;
  } ccz_time_t;

  // One input item after unpacking
  typedef struct packed {
    ccz_mode_e   mode;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } ccz_item_t;

endpackage

`default_nettype wire

[sv/ccz_calc.sv]
// Next-state logic of the clock: tick, set with clamping, and zone shift.
`default_nettype none

module ccz_calc (
  input  ccz_pkg::ccz_time_t cur_i,
  input  ccz_pkg::ccz_item_t item_i,
  input  logic [4:0]         offset_i,
  output ccz_pkg::ccz_time_t nxt_o
);
  import ccz_pkg::*;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } ccz_date_t;

  // 2^19 / 100, rounded up; exact quotient for years up to 9999
  localparam logic [26:0] YearRecip = 27'd5243;
  localparam logic [4:0]  MonthLen [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  localparam logic [4:0]  FebLeap = 5'd29;

  // Gregorian leap year via y / 100 by reciprocal multiplication
  function automatic logic leap_year(input logic [13:0] y);
    logic [26:0] prod;
    logic [6:0]  q;
    logic [13:0] hund;
    prod = {13'd0, y} * YearRecip;
    q    = prod[25:19];
    hund = {7'd0, q} * 14'd100;
    return (y[1:0] == 2'd0) && ((hund != y) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    if (m < 4'd1 || m > MonthMax) idx = 4'd0;
    else                          idx = m - 4'd1;
    if (m == 4'd2 && leap) return FebLeap;
    return MonthLen[idx];
  endfunction

  function automatic ccz_date_t day_fwd(input ccz_date_t d, input logic leap);
    ccz_date_t r;
    r = d;
    if (d.day >= days_in(d.month, leap)) begin
      r.day = 5'd1;
      if (d.month >= MonthMax) begin
        r.month = 4'd1;
        r.year  = (d.year >= YearMax) ? 14'd0 : d.year + 14'd1;
      end else begin
        r.month = d.month + 4'd1;
      end
    end else begin
      r.day = d.day + 5'd1;
    end
    return r;
  endfunction

  // December is never a leap-dependent month, so the current year's flag serves
  function automatic ccz_date_t day_bk(input ccz_date_t d, input logic leap);
    ccz_date_t r;
    r = d;
    if (d.day <= 5'd1) begin
      if (d.month <= 4'd1) begin
        r.month = MonthMax;
        r.year  = (d.year == 14'd0) ? YearMax : d.year - 14'd1;
      end else begin
        r.month = d.month - 4'd1;
      end
      r.day = days_in(r.month, leap);
    end else begin
      r.day = d.day - 5'd1;
    end
    return r;
  endfunction

  ccz_date_t   cur_date, fwd_date, back_date;
  logic        leap_cur, leap_set;
  logic [3:0]  set_month;
  logic [13:0] set_year;
  logic [4:0]  set_lim, off;
  logic [5:0]  hour_sum, hour_back;

  // Shared day carry and borrow on the current date
  assign cur_date  = '{day: cur_i.day, month: cur_i.month, year: cur_i.year};
  assign leap_cur  = leap_year(cur_i.year);
  assign fwd_date  = day_fwd(cur_date, leap_cur);
  assign back_date = day_bk(cur_date, leap_cur);

  // Clamp the loaded month and year, then the day against that month
  assign set_month = (item_i.month < 4'd1) ? 4'd1 :
                     (item_i.month > MonthMax) ? MonthMax : item_i.month;
  assign set_year  = (item_i.year > YearMax) ? YearMax : item_i.year;
  assign leap_set  = leap_year(set_year);
  assign set_lim   = days_in(set_month, leap_set);

  // Zone offset arithmetic
  assign off       = (offset_i > OffsetMax) ? OffsetMax : offset_i;
  assign hour_sum  = {1'b0, cur_i.hour} + {1'b0, off};
  assign hour_back = {1'b0, cur_i.hour} + HoursDay - {1'b0, off};

  always_comb begin
    nxt_o = cur_i;
    case (item_i.mode)
      ModeTick: begin
        if (cur_i.sec >= SecMax) begin
          nxt_o.sec = 6'd0;
          if (cur_i.min >= MinMax) begin
            nxt_o.min = 6'd0;
            if (cur_i.hour >= HourMax) begin
              nxt_o.hour  = 5'd0;
              nxt_o.day   = fwd_date.day;
              nxt_o.month = fwd_date.month;
              nxt_o.year  = fwd_date.year;
            end else begin
              nxt_o.hour = cur_i.hour + 5'd1;
            end
          end else begin
            nxt_o.min = cur_i.min + 6'd1;
          end
        end else begin
          nxt_o.sec = cur_i.sec + 6'd1;
        end
      end
      ModeSet: begin
        nxt_o.weekday = item_i.weekday;
        nxt_o.month   = set_month;
        nxt_o.year    = set_year;
        nxt_o.day     = (item_i.day < 5'd1) ? 5'd1 :
                        (item_i.day > set_lim) ? set_lim : item_i.day;
        nxt_o.hour    = (item_i.hours > HourMax) ? HourMax : item_i.hours;
        nxt_o.min     = (item_i.minutes > MinMax) ? MinMax : item_i.minutes;
        nxt_o.sec     = (item_i.seconds > SecMax) ? SecMax : item_i.seconds;
      end
      ModeZone: begin
        if (!cur_i.zone) begin
          // Enter the US zone: move back, borrow a day if needed
          nxt_o.zone = 1'b1;
          if ({1'b0, cur_i.hour} < {1'b0, off}) begin
            nxt_o.hour  = hour_back[4:0];
            nxt_o.day   = back_date.day;
            nxt_o.month = back_date.month;
            nxt_o.year  = back_date.year;
            if (cur_i.weekday != WdUnknown) begin
              nxt_o.weekday = (cur_i.weekday == WdMonday) ? WdSunday
                                                          : cur_i.weekday - 3'd1;
            end
          end else begin
            nxt_o.hour = cur_i.hour - off;
          end
        end else begin
          // Leave the US zone: move forward, carry a day if needed
          nxt_o.zone = 1'b0;
          if (hour_sum >= HoursDay) begin
            nxt_o.hour  = 5'(hour_sum - HoursDay);
            nxt_o.day   = fwd_date.day;
            nxt_o.month = fwd_date.month;
            nxt_o.year  = fwd_date.year;
            if (cur_i.weekday != WdUnknown) begin
              nxt_o.weekday = (cur_i.weekday >= WdSunday) ? WdMonday
                                                          : cur_i.weekday + 3'd1;
            end
          end else begin
            nxt_o.hour = hour_sum[4:0];
          end
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/calendar_clock_with_zone_shift.sv]
// Throughput: one transaction per cycle unless the output stalls; one input register
// feeds the clock update, and the clock state register is also the output register.
// Reset: asynchronous, active low; clears both valid flags and loads 00:00:00,
// 1 January 2000, weekday unknown, home zone, offset 6 hours.
`default_nettype none

module calendar_clock_with_zone_shift (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,     // zone_offset_hours
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // set_weekday[2:0], set_day[7:3], set_month[11:8], set_year[25:12],
  // set_hours[30:26], set_minutes[36:31], set_seconds[42:37], zero pad
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,    // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // now_seconds[5:0], now_minutes[11:6], now_hours[16:12], now_day[21:17],
  // now_month[25:22], now_year[39:26], now_weekday[42:40], zero pad
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tuser     // in_us_zone
);
  import ccz_pkg::*;

  logic      in_valid_q, out_valid_q, advance;
  ccz_item_t item_d, item_q;
  ccz_time_t time_d, time_q;
  logic [4:0] offset_q;

  // Move one item forward when the output stage is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Unpack the input transaction
  assign item_d = '{mode:    ccz_mode_e'(s_axis_tuser),
                    weekday: s_axis_tdata[2:0],
                    day:     s_axis_tdata[7:3],
                    month:   s_axis_tdata[11:8],
                    year:    s_axis_tdata[25:12],
                    hours:   s_axis_tdata[30:26],
                    minutes: s_axis_tdata[36:31],
                    seconds: s_axis_tdata[42:37]};

  // Hold the zone offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_d;
    end
  end

  ccz_calc u_calc (
    .cur_i    (time_q),
    .item_i   (item_q),
    .offset_i (offset_q),
    .nxt_o    (time_d)
  );

  // Update the clock state, which is the result shown on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '{sec: 6'd0, min: 6'd0, hour: 5'd0, day: DayReset,
                  month: MonthReset, year: YearReset, weekday: WdUnknown, zone: 1'b0};
    end else if (advance) begin
      time_q <= time_d;
    end
  end

  // Output valid: set by a finished item, dropped once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, time_q.weekday, time_q.year, time_q.month, time_q.day,
                          time_q.hour, time_q.min, time_q.sec};
  assign m_axis_tuser  = time_q.zone;

endmodule

`default_nettype wire

[sv/ccz_checker.sv]
// Port-level checks of the calendar clock, bound to the top level.
`default_nettype none

module ccz_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // With no result pending the input side is open
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // An item taken while no result is shown is followed by a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result missing after accepted item");

  // Every shown date and time lies within its range
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[5:0] <= 6'd59) && (m_axis_tdata[11:6] <= 6'd59) &&
      (m_axis_tdata[16:12] <= 5'd23) && (m_axis_tdata[21:17] >= 5'd1) &&
      (m_axis_tdata[25:22] >= 4'd1) && (m_axis_tdata[25:22] <= 4'd12) &&
      (m_axis_tdata[39:26] <= 14'd9999))
    else $error("date or time out of range");

endmodule

bind calendar_clock_with_zone_shift ccz_checker u_ccz_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
